// ===== rtl/svf_pkg.sv =====
// Package for the state variable filter: widths, codes, word types and microcode program.
package svf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int STATE_W  = 32;
    localparam int COEF_W   = 32;

    localparam int COEF_FRAC = 30;
    localparam int DAMP_FRAC = 28;

    // configuration register widths
    localparam int FT_W       = 2;
    localparam int A1_W       = 31;
    localparam int A2_W       = 30;
    localparam int A3_W       = 31;
    localparam int K_W        = (COEF_W < 32) ? COEF_W : 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [A1_W-1:0] A1_RESET = A1_W'(64'd1 << COEF_FRAC);
    localparam logic [K_W-1:0]  K_RESET  = K_W'(64'd379682357);

    // datapath widths
    localparam int OPER_W = ((STATE_W > COEF_W) ? STATE_W : COEF_W) + 1;
    localparam int PROD_W = 2 * OPER_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int WIDE_W = ACC_W - DAMP_FRAC + 2;

    // saturation bounds at datapath width
    localparam logic signed [WIDE_W-1:0] STATE_HI =
        {{(WIDE_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] STATE_LO =
        {{(WIDE_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] SAMPLE_HI =
        {{(WIDE_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAMPLE_LO =
        {{(WIDE_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    // sequencer
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_FIRST  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_FINISH = STEP_W'(7);

    typedef enum logic [FT_W-1:0] {
        FT_LOWPASS  = 2'd0,
        FT_BANDPASS = 2'd1,
        FT_HIGHPASS = 2'd2
    } filter_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_TYPE = 3'd0,
        CFG_COEF_A1     = 3'd1,
        CFG_COEF_A2     = 3'd2,
        CFG_COEF_A3     = 3'd3,
        CFG_DAMPING_K   = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        MA_A1,
        MA_A2,
        MA_A3,
        MA_K
    } mul_a_sel_t;

    typedef enum logic [1:0] {
        MB_S1,
        MB_V3,
        MB_V1
    } mul_b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_COEF,
        ACC_LOAD_DAMP,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       clear_state;
    } svf_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } svf_out_t;

    typedef struct packed {
        logic              mul_en;
        mul_a_sel_t        mul_a;
        mul_b_sel_t        mul_b;
        acc_op_t           acc_op;
        logic              wr_v1;
        logic              wr_v2;
        logic              jmp_nhp;
        logic [STEP_W-1:0] jmp_to;
        logic              last;
    } ctrl_t;

    // Microcode program. A product issued at a step is held in the product register for later steps.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        cw = '0;
        case (step)
            3'd0: begin
                cw.mul_en = 1'b1; cw.mul_a = MA_A1; cw.mul_b = MB_S1;
            end
            3'd1: begin
                cw.mul_en = 1'b1; cw.mul_a = MA_A2; cw.mul_b = MB_V3;
                cw.acc_op = ACC_LOAD_COEF;
            end
            3'd2: begin
                cw.mul_en = 1'b1; cw.mul_a = MA_A2; cw.mul_b = MB_S1;
                cw.acc_op = ACC_ADD;
            end
            3'd3: begin
                cw.mul_en = 1'b1; cw.mul_a = MA_A3; cw.mul_b = MB_V3;
                cw.acc_op = ACC_LOAD_COEF;
                cw.wr_v1  = 1'b1;
            end
            3'd4: begin
                cw.acc_op = ACC_ADD;
            end
            3'd5: begin
                cw.mul_en  = 1'b1; cw.mul_a = MA_K; cw.mul_b = MB_V1;
                cw.wr_v2   = 1'b1;
                cw.jmp_nhp = 1'b1;
                cw.jmp_to  = STEP_FINISH;
            end
            3'd6: begin
                cw.acc_op = ACC_LOAD_DAMP;
            end
            3'd7: begin
                cw.last = 1'b1;
            end
            default: begin
                cw.last = 1'b1;
            end
        endcase
        return cw;
    endfunction

    function automatic logic state_ovf(input logic signed [WIDE_W-1:0] x);
        return (x > STATE_HI) || (x < STATE_LO);
    endfunction

    function automatic logic signed [STATE_W-1:0] clamp_state(
        input logic signed [WIDE_W-1:0] x
    );
        logic signed [STATE_W-1:0] r;
        if (x > STATE_HI) begin
            r = {1'b0, {(STATE_W-1){1'b1}}};
        end else if (x < STATE_LO) begin
            r = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            r = STATE_W'(x);
        end
        return r;
    endfunction

    function automatic logic sample_ovf(input logic signed [WIDE_W-1:0] x);
        return (x > SAMPLE_HI) || (x < SAMPLE_LO);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(
        input logic signed [WIDE_W-1:0] x
    );
        logic signed [SAMPLE_W-1:0] r;
        if (x > SAMPLE_HI) begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (x < SAMPLE_LO) begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            r = SAMPLE_W'(x);
        end
        return r;
    endfunction

endpackage

// ===== rtl/state_variable_filter_core.sv =====
// Top level of the trapezoidal state variable filter: microcoded datapath and handshakes.

// Trapezoidal state variable filter, one signed 24-bit sample word in, one filtered
// word out. Two 32-bit integrators are kept between samples; clear_state on an input
// word zeroes them before that sample is used. filter_type picks lowpass, bandpass or
// highpass (code 3 returns zero but still updates the integrators). Coefficients a1
// and a3 are Q1.30, a2 is Q0.30, damping_k is Q4.28, all unsigned, computed by software.
// Every product runs through one shared 33x33 signed multiplier under control of an
// eight-step microcode program. In highpass mode a sample runs all eight steps (five
// products); otherwise a conditional jump skips the step that loads the damping
// product, which is left unused; s_ready is high only between samples. A finished
// word sits in the output register, and the core holds its last step until that
// register is free. Configuration writes are taken every cycle (cfg_ready is tied
// high) and must only happen while the core is idle; unknown indexes are dropped.
module state_variable_filter_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  svf_pkg::svf_in_t                    s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output svf_pkg::svf_out_t                   m_data,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [svf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [svf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SAMPLE_W = svf_pkg::SAMPLE_W;
    localparam int STATE_W  = svf_pkg::STATE_W;
    localparam int OPER_W   = svf_pkg::OPER_W;
    localparam int PROD_W   = svf_pkg::PROD_W;
    localparam int ACC_W    = svf_pkg::ACC_W;
    localparam int WIDE_W   = svf_pkg::WIDE_W;
    localparam int STEP_W   = svf_pkg::STEP_W;

    localparam logic signed [ACC_W-1:0] ROUND_COEF = ACC_W'(1) <<< (svf_pkg::COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] ROUND_DAMP = ACC_W'(1) <<< (svf_pkg::DAMP_FRAC - 1);

    // configuration registers
    logic [svf_pkg::FT_W-1:0] ft_reg;
    logic [svf_pkg::A1_W-1:0] a1_reg;
    logic [svf_pkg::A2_W-1:0] a2_reg;
    logic [svf_pkg::A3_W-1:0] a3_reg;
    logic [svf_pkg::K_W-1:0]  k_reg;

    // sequencer
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    svf_pkg::ctrl_t    cw;
    logic              in_fire;
    logic              finish;

    // datapath
    logic signed [STATE_W-1:0]  s1_reg, s2_reg;
    logic signed [SAMPLE_W-1:0] v0_reg;
    logic signed [OPER_W-1:0]   v3_reg;
    logic signed [STATE_W-1:0]  v1_reg, v2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       clip_reg;

    logic signed [OPER_W-1:0]   mul_a, mul_b;
    logic signed [WIDE_W-1:0]   acc_coef, acc_damp;
    logic signed [WIDE_W-1:0]   v1_wide, v2_wide;
    logic signed [WIDE_W-1:0]   s1_wide, s2_wide, res_wide;
    logic                       res_hit;

    // output register
    logic              m_valid_reg, m_valid_next;
    svf_pkg::svf_out_t m_data_reg;

    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign in_fire = s_valid && s_ready;
    assign cw      = svf_pkg::ucode(step_reg);
    // The last step retires only once the output register can take the word.
    assign finish  = busy_reg && cw.last && (!m_valid_reg || m_ready);

    // Configuration writes; drop unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ft_reg <= svf_pkg::FT_LOWPASS;
            a1_reg <= svf_pkg::A1_RESET;
            a2_reg <= '0;
            a3_reg <= '0;
            k_reg  <= svf_pkg::K_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                svf_pkg::CFG_FILTER_TYPE: ft_reg <= cfg_data[svf_pkg::FT_W-1:0];
                svf_pkg::CFG_COEF_A1:     a1_reg <= cfg_data[svf_pkg::A1_W-1:0];
                svf_pkg::CFG_COEF_A2:     a2_reg <= cfg_data[svf_pkg::A2_W-1:0];
                svf_pkg::CFG_COEF_A3:     a3_reg <= cfg_data[svf_pkg::A3_W-1:0];
                svf_pkg::CFG_DAMPING_K:   k_reg  <= cfg_data[svf_pkg::K_W-1:0];
                default: ;
            endcase
        end
    end

    // Step counter: advance, take the jump past the damping product unless highpass,
    // hold on the last step while the output is full.
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (in_fire) begin
            busy_next = 1'b1;
            step_next = svf_pkg::STEP_FIRST;
        end else if (busy_reg) begin
            if (cw.last) begin
                if (finish) begin
                    busy_next = 1'b0;
                    step_next = svf_pkg::STEP_FIRST;
                end
            end else if (cw.jmp_nhp && (ft_reg != svf_pkg::FT_HIGHPASS)) begin
                step_next = cw.jmp_to;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= svf_pkg::STEP_FIRST;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Multiplier operand selection: coefficients zero-extended, data sign-extended.
    always_comb begin
        case (cw.mul_a)
            svf_pkg::MA_A1: mul_a = $signed(OPER_W'(a1_reg));
            svf_pkg::MA_A2: mul_a = $signed(OPER_W'(a2_reg));
            svf_pkg::MA_A3: mul_a = $signed(OPER_W'(a3_reg));
            svf_pkg::MA_K:  mul_a = $signed(OPER_W'(k_reg));
            default:        mul_a = '0;
        endcase
        case (cw.mul_b)
            svf_pkg::MB_S1: mul_b = OPER_W'(s1_reg);
            svf_pkg::MB_V3: mul_b = v3_reg;
            svf_pkg::MB_V1: mul_b = OPER_W'(v1_reg);
            default:        mul_b = '0;
        endcase
    end

    // Rounded views of the accumulator (rounding bias was added at load).
    assign acc_coef = WIDE_W'(acc_reg >>> svf_pkg::COEF_FRAC);
    assign acc_damp = WIDE_W'(acc_reg >>> svf_pkg::DAMP_FRAC);
    assign v1_wide  = acc_coef;
    assign v2_wide  = WIDE_W'(s2_reg) + acc_coef;

    // Integrator update and response select on the last step.
    assign s1_wide = (WIDE_W'(v1_reg) <<< 1) - WIDE_W'(s1_reg);
    assign s2_wide = (WIDE_W'(v2_reg) <<< 1) - WIDE_W'(s2_reg);

    always_comb begin
        case (ft_reg)
            svf_pkg::FT_LOWPASS:  res_wide = WIDE_W'(v2_reg);
            svf_pkg::FT_BANDPASS: res_wide = WIDE_W'(v1_reg);
            svf_pkg::FT_HIGHPASS: res_wide = WIDE_W'(v0_reg) - acc_damp - WIDE_W'(v2_reg);
            default:              res_wide = '0;
        endcase
    end

    assign res_hit = svf_pkg::sample_ovf(res_wide) || svf_pkg::state_ovf(s1_wide)
                     || svf_pkg::state_ovf(s2_wide);

    // Integrators: zero on reset and on a clearing word, update on retire.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else if (in_fire && s_data.clear_state) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else if (finish) begin
            s1_reg <= svf_pkg::clamp_state(s1_wide);
            s2_reg <= svf_pkg::clamp_state(s2_wide);
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            v0_reg <= s_data.sample_in;
            if (s_data.clear_state) begin
                v3_reg <= OPER_W'(s_data.sample_in);
            end else begin
                v3_reg <= OPER_W'(s_data.sample_in) - OPER_W'(s2_reg);
            end
        end

        if (busy_reg && cw.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end

        if (busy_reg) begin
            case (cw.acc_op)
                svf_pkg::ACC_LOAD_COEF: acc_reg <= ACC_W'(prod_reg) + ROUND_COEF;
                svf_pkg::ACC_LOAD_DAMP: acc_reg <= ACC_W'(prod_reg) + ROUND_DAMP;
                svf_pkg::ACC_ADD:       acc_reg <= acc_reg + ACC_W'(prod_reg);
                default: ;
            endcase
        end

        if (busy_reg && cw.wr_v1) begin
            v1_reg <= svf_pkg::clamp_state(v1_wide);
        end
        if (busy_reg && cw.wr_v2) begin
            v2_reg <= svf_pkg::clamp_state(v2_wide);
        end

        if (finish) begin
            m_data_reg.sample_out <= svf_pkg::clamp_sample(res_wide);
            m_data_reg.clipped    <= clip_reg || res_hit;
        end
    end

    // Stage saturation flag, collected across the program.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg <= 1'b0;
        end else if (in_fire) begin
            clip_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cw.wr_v1 && svf_pkg::state_ovf(v1_wide)) begin
                clip_reg <= 1'b1;
            end
            if (cw.wr_v2 && svf_pkg::state_ovf(v2_wide)) begin
                clip_reg <= 1'b1;
            end
        end
    end

    // Output word register: load on retire, drop on take.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (finish) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTH
    a_start_at_first_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (busy_reg && step_reg == svf_pkg::STEP_FIRST))
        else $error("sample accepted but program did not start at first step");

    a_idle_at_first_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (step_reg == svf_pkg::STEP_FIRST))
        else $error("step counter moved while idle");

    a_output_only_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !cw.last && m_valid_reg && m_ready) |=> !m_valid_reg)
        else $error("output word produced before the last step");

    a_retire_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (s_ready && m_valid_reg))
        else $error("retire did not free the core and load the output");
`endif

endmodule

// ===== sim/tb_state_variable_filter_core.sv =====
// Self-checking testbench for the state variable filter core: bit-exact prediction and scoreboard.
`timescale 1ns / 1ps

module tb_state_variable_filter_core;

    typedef logic signed [79:0] wide_t;

    localparam int FT_W       = svf_pkg::FT_W;
    localparam int CFG_IDX_W  = svf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = svf_pkg::CFG_DATA_W;
    localparam int SAMPLE_W   = svf_pkg::SAMPLE_W;
    localparam int STATE_W    = svf_pkg::STATE_W;
    localparam int COEF_FRAC  = svf_pkg::COEF_FRAC;
    localparam int DAMP_FRAC  = svf_pkg::DAMP_FRAC;
    localparam int A1_W       = svf_pkg::A1_W;
    localparam int A2_W       = svf_pkg::A2_W;
    localparam int A3_W       = svf_pkg::A3_W;
    localparam int K_W        = svf_pkg::K_W;

    localparam int QUIET_LIMIT = 5000;  // cycles with no word moving on any channel
    localparam int HOLD_OFF    = 400;   // long receiver stall used to fill the core

    localparam logic [FT_W-1:0]      FT_SPARE        = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    svf_pkg::svf_in_t      s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    svf_pkg::svf_out_t     m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // filter settings and integrators as the core should hold them
    logic [FT_W-1:0] cur_type;
    longint          cur_a1, cur_a2, cur_a3, cur_k;
    longint          band_state, low_state;

    svf_pkg::svf_out_t filtered_words[$];   // filtered words still owed by the core
    int       error_count  = 0;
    int       quiet_cycles = 0;
    int       rx_hold_len  = 0;    // nonzero asks the receiver to stall that many cycles
    bit       steady_flow  = 1'b0; // no random idling on either side

    state_variable_filter_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // round half up: floor(x / 2^sh + 1/2)
    function automatic wide_t round_half_up(input wide_t x, input int sh);
        return (x + (wide_t'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic wide_t clamp_signed(input wide_t x, input int bits, inout logic hit);
        wide_t hi, lo;
        hi = (wide_t'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (x < lo) begin
            hit = 1'b1;
            return lo;
        end
        return x;
    endfunction

    // One trapezoidal step: band and low integrators, then the selected response.
    function automatic svf_pkg::svf_out_t run_filter(input svf_pkg::svf_in_t w);
        wide_t             x0, s1, s2, v1, v2, v3, y;
        logic              hit;
        svf_pkg::svf_out_t r;
        hit = 1'b0;
        if (w.clear_state) begin
            band_state = 0;
            low_state  = 0;
        end
        x0 = wide_t'(signed'(w.sample_in));
        s1 = wide_t'(band_state);
        s2 = wide_t'(low_state);
        v3 = x0 - s2;
        v1 = round_half_up(wide_t'(cur_a1) * s1 + wide_t'(cur_a2) * v3, COEF_FRAC);
        v1 = clamp_signed(v1, STATE_W, hit);
        v2 = s2 + round_half_up(wide_t'(cur_a2) * s1 + wide_t'(cur_a3) * v3, COEF_FRAC);
        v2 = clamp_signed(v2, STATE_W, hit);
        band_state = longint'(clamp_signed(2 * v1 - s1, STATE_W, hit));
        low_state  = longint'(clamp_signed(2 * v2 - s2, STATE_W, hit));
        case (cur_type)
            svf_pkg::FT_LOWPASS:  y = v2;
            svf_pkg::FT_BANDPASS: y = v1;
            svf_pkg::FT_HIGHPASS: y = x0 - round_half_up(wide_t'(cur_k) * v1, DAMP_FRAC) - v2;
            default:              y = '0;
        endcase
        y = clamp_signed(y, SAMPLE_W, hit);
        r.sample_out = y[SAMPLE_W-1:0];
        r.clipped    = hit;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one sample word; hold it until taken, then predict its output word.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp, input logic clr);
        svf_pkg::svf_in_t w;
        int               gap;
        w.sample_in   = smp;
        w.clear_state = clr;
        gap = (!steady_flow && $urandom_range(99) < 29) ? $urandom_range(1, 12) : 0;
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        filtered_words.push_back(run_filter(w));
    endtask

    task automatic send_random(input int count, input int clear_pct);
        repeat (count) push_sample(SAMPLE_W'($urandom), $urandom_range(99) < clear_pct);
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (filtered_words.size() != 0) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that writes can go back to back; callers lower it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            svf_pkg::CFG_FILTER_TYPE: cur_type = value[FT_W-1:0];
            svf_pkg::CFG_COEF_A1:     cur_a1   = longint'(value[A1_W-1:0]);
            svf_pkg::CFG_COEF_A2:     cur_a2   = longint'(value[A2_W-1:0]);
            svf_pkg::CFG_COEF_A3:     cur_a3   = longint'(value[A3_W-1:0]);
            svf_pkg::CFG_DAMPING_K:   cur_k    = longint'(value[K_W-1:0]);
            default: ;  // unknown index: drop
        endcase
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] ft, a1, a2, a3, k);
        write_reg(svf_pkg::CFG_FILTER_TYPE, ft);
        write_reg(svf_pkg::CFG_COEF_A1, a1);
        write_reg(svf_pkg::CFG_COEF_A2, a2);
        write_reg(svf_pkg::CFG_COEF_A3, a3);
        write_reg(svf_pkg::CFG_DAMPING_K, k);
        cfg_valid <= 1'b0;
    endtask

    // Coefficients of a stable filter for a random prewarped cutoff g and damping k.
    task automatic load_tuned(input logic [FT_W-1:0] ftype);
        real g, k, a1, a2, a3;
        g  = $urandom_range(10, 3000) / 1000.0;
        k  = $urandom_range(50, 2000) / 1000.0;
        a1 = 1.0 / (1.0 + g * (g + k));
        a2 = g * a1;
        a3 = g * a2;
        load_config(CFG_DATA_W'(ftype), $rtoi(a1 * 1073741824.0), $rtoi(a2 * 1073741824.0),
                    $rtoi(a3 * 1073741824.0), $rtoi(k * 268435456.0));
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Stall at random; on request hold off for a long stretch so the core backs up.
    initial begin
        int hold;
        forever begin
            @(posedge aclk);
            if (rx_hold_len != 0) begin
                hold        = rx_hold_len;
                rx_hold_len = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= steady_flow || ($urandom_range(99) >= 29);
        end
    end

    // Compare each accepted output word with the oldest prediction.
    always @(posedge aclk) begin : check_output
        svf_pkg::svf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (filtered_words.size() == 0) begin
                $display("%0t: unexpected output word sample_out=%0d clipped=%0b",
                         $time, m_data.sample_out, m_data.clipped);
                error_count++;
            end else begin
                want = filtered_words.pop_front();
                if (m_data.sample_out !== want.sample_out) begin
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, want.sample_out, m_data.sample_out);
                    error_count++;
                end
                if (m_data.clipped !== want.clipped) begin
                    $display("%0t: clipped expected %0b actual %0b",
                             $time, want.clipped, m_data.clipped);
                    error_count++;
                end
            end
        end
    end

    // Count cycles in which no word moves on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("%0t: timeout, no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: lowpass with a2 = a3 = 0, so the output stays at zero.
    task automatic test_reset_defaults();
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);
    endtask

    // Full-scale inputs under mild, zero and maximum coefficients.
    task automatic test_saturation_corners();
        drain_results();
        // g = 1, k = 1: all three coefficients one third, unity damping
        load_config(CFG_DATA_W'(svf_pkg::FT_HIGHPASS), 32'd357913941, 32'd357913941,
                    32'd357913941, 32'd268435456);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);
        drain_results();
        load_config(CFG_DATA_W'(svf_pkg::FT_BANDPASS), '0, '0, '0, '0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        // all-ones data: every coefficient lands on its largest value, far above range,
        // so the integrators run away into state and output saturation
        drain_results();
        load_config(CFG_DATA_W'(svf_pkg::FT_HIGHPASS), '1, '1, '1, '1);
        repeat (6) push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MIN, 1'b1);
    endtask

    // Writes to indexes past the register list are dropped; response code 3 gives zero.
    task automatic test_spare_codes();
        drain_results();
        write_reg(CFG_SPARE_FIRST, $urandom);
        write_reg(CFG_SPARE_LAST, $urandom);
        write_reg(svf_pkg::CFG_FILTER_TYPE, {{(CFG_DATA_W-FT_W){1'b1}}, FT_SPARE});
        cfg_valid <= 1'b0;
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
    endtask

    task automatic test_tuned_sweeps();
        for (int phase = 0; phase < 8; phase++) begin
            drain_results();
            load_tuned(FT_W'(phase % 4));
            send_random(55, 3);
        end
    endtask

    // Raw random register data, reaching coefficients well above their nominal range.
    task automatic test_wild_coefficients();
        repeat (2) begin
            drain_results();
            load_config($urandom, $urandom, $urandom, $urandom, $urandom);
            send_random(40, 10);
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the core stalls its input.
    task automatic test_output_backpressure();
        drain_results();
        load_tuned(svf_pkg::FT_HIGHPASS);
        rx_hold_len = HOLD_OFF;
        send_random(25, 3);
    endtask

    task automatic test_sender_pause();
        send_random(15, 3);
        drain_results();
        send_random(15, 3);
    endtask

    task automatic test_steady_stream();
        drain_results();
        steady_flow = 1'b1;
        load_tuned(svf_pkg::FT_LOWPASS);
        send_random(60, 2);
        drain_results();
        steady_flow = 1'b0;
    endtask

    initial begin
        cur_type   = svf_pkg::FT_LOWPASS;
        cur_a1     = longint'(svf_pkg::A1_RESET);
        cur_a2     = 0;
        cur_a3     = 0;
        cur_k      = longint'(svf_pkg::K_RESET);
        band_state = 0;
        low_state  = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_saturation_corners();
        test_spare_codes();
        test_tuned_sweeps();
        test_wild_coefficients();
        test_output_backpressure();
        test_sender_pause();
        test_steady_stream();

        drain_results();
        repeat (20) @(posedge aclk);
        if (filtered_words.size() != 0) begin
            $display("%0t: %0d output words never arrived", $time, filtered_words.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
